>>> sv/b64d_pkg.sv
// b64d_pkg: shared types, constants and helper functions of the lenient Base64 decoder.
// No dependencies; used by the front, queue, back and core modules.
package b64d_pkg;

	// Default depth of the job queue between front and back.
	localparam int unsigned QueueDepth = 4;

	localparam logic [7:0] PadChar = 8'h3D;	// '='

	// Number of results a job carries: 1..3.
	typedef logic [1:0] job_cnt_t;

	// One job: the results caused by one accepted character.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		job_cnt_t   cnt;
		logic       valid;	// 0 marks the empty end marker
		logic       last;	// last flag goes on the final result of the job
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	// Alphabet lookup.
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r.ok  = 1'b1;
		r.val = 6'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			r.val = 6'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7A]}) begin
			r.val = 6'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30:8'h39]}) begin
			r.val = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r.val = 6'd62;
		end else if (c == 8'h2F) begin
			r.val = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	// First byte of a group: all of s0, top two bits of s1.
	function automatic logic [7:0] pack0(input logic [5:0] s0, input logic [5:0] s1);
		return {s0, s1[5:4]};
	endfunction

	// Second byte: low nibble of s1, top nibble of s2.
	function automatic logic [7:0] pack1(input logic [5:0] s1, input logic [5:0] s2);
		return {s1[3:0], s2[5:2]};
	endfunction

	// Third byte: low two bits of s2, all of s3.
	function automatic logic [7:0] pack2(input logic [5:0] s2, input logic [5:0] s3);
		return {s2[1:0], s3};
	endfunction

endpackage

>>> sv/b64d_front.sv
// b64d_front: character classification and group state; turns each accepted
// character into at most one job. Depends on b64d_pkg.
module b64d_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       in_char,
	input  logic             in_last,
	output logic             job_push,
	output b64d_pkg::job_t   job
);

	logic [1:0]        group_count_q;
	logic [5:0]        held_q [3];
	logic              pad_seen_q;

	logic [1:0]        gc_n;
	logic [5:0]        held_n [3];
	logic              pad_n;
	logic              complete;
	b64d_pkg::sextet_t sx;

	always_comb begin
		sx       = b64d_pkg::sextet_of(in_char);
		gc_n     = group_count_q;
		held_n   = held_q;
		pad_n    = pad_seen_q;
		complete = 1'b0;
		if (!pad_seen_q) begin
			if (in_char == b64d_pkg::PadChar) begin
				pad_n = 1'b1;
			end else if (sx.ok) begin
				if (group_count_q == 2'd3) begin
					complete = 1'b1;
					gc_n     = 2'd0;
				end else begin
					held_n[group_count_q] = sx.val;
					gc_n = group_count_q + 2'd1;
				end
			end
		end
	end

	always_comb begin
		job       = '0;
		job.last  = in_last;
		job.valid = 1'b1;
		if (complete) begin
			job.b0  = b64d_pkg::pack0(held_q[0], held_q[1]);
			job.b1  = b64d_pkg::pack1(held_q[1], held_q[2]);
			job.b2  = b64d_pkg::pack2(held_q[2], sx.val);
			job.cnt = 2'd3;
		end else if (gc_n >= 2'd2) begin
			// flush of a partial group at message end
			job.b0  = b64d_pkg::pack0(held_n[0], held_n[1]);
			job.b1  = b64d_pkg::pack1(held_n[1], held_n[2]);
			job.cnt = gc_n - 2'd1;
		end else begin
			// empty end marker
			job.cnt   = 2'd1;
			job.valid = 1'b0;
		end
		job_push = accept && (complete || in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q <= 2'd0;
			pad_seen_q    <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				group_count_q <= 2'd0;
				pad_seen_q    <= 1'b0;
			end else begin
				group_count_q <= gc_n;
				pad_seen_q    <= pad_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_n;
		end
	end

endmodule

>>> sv/b64d_queue.sv
// b64d_queue: short job queue that decouples front and back.
// Depends on b64d_pkg for the job type.
module b64d_queue #(
	parameter int unsigned DEPTH = b64d_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  b64d_pkg::job_t wr_job,
	input  logic           rd_en,
	output b64d_pkg::job_t rd_job,
	output logic           q_full,
	output logic           q_empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	b64d_pkg::job_t  slots_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign q_full  = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_job  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= bump(wr_ptr_q);
			if (rd_en) rd_ptr_q <= bump(rd_ptr_q);
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

>>> sv/b64d_back.sv
// b64d_back: walks the head job into the output register, one result per cycle while it is free or popped.
// Depends on b64d_pkg for the job type.
module b64d_back (
	input  logic           clk,
	input  logic           arst_n,
	input  b64d_pkg::job_t head,
	input  logic           head_ok,
	output logic           head_done,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     out_byte,
	output logic           out_valid,
	output logic           out_last
);

	logic [1:0] idx_q;
	logic       full_q;
	logic       advance;
	logic       take;
	logic       at_end;
	logic [7:0] sel_byte;

	assign advance   = !full_q || pop;
	assign take      = advance && head_ok;
	assign at_end    = (idx_q == head.cnt - 2'd1);
	assign head_done = take && at_end;
	assign empty     = !full_q;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.b0;
			2'd1:    sel_byte = head.b1;
			2'd2:    sel_byte = head.b2;
			default: sel_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 2'd0;
			full_q <= 1'b0;
		end else begin
			if (advance) full_q <= head_ok;
			if (take) idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte  <= sel_byte;
			out_valid <= head.valid;
			out_last  <= head.last && at_end;
		end
	end

endmodule

>>> sv/base64_lenient_decoder_core.sv
// Lenient Base64 decoder core: one character per request in, one byte per request out.
// A character's job goes into the queue, then its results into the output register.
// Throughput: one character per cycle; the back end drains one result per cycle, and a
//   job with k results is always preceded by at least k-1 characters with no result,
//   so with pop held high the back end keeps up; full rises only when pop stalls leave
//   QUEUE_DEPTH jobs waiting.
// Reset: arst_n clears group count, pad flag, queue pointers and back-end full flag; empty=1.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
module base64_lenient_decoder_core #(
	parameter int unsigned QUEUE_DEPTH = b64d_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	// character side
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_char,
	input  logic       in_last,
	// result side
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       out_last
);

	b64d_pkg::job_t new_job;
	b64d_pkg::job_t head_job;
	logic           accept;
	logic           job_push;
	logic           q_empty;
	logic           head_done;

	// A request is taken whenever the queue has a free slot, even if the
	// character ends up producing no job (skipped or after the pad).
	assign accept = push && !full;

	// Front: alphabet lookup, group/pad tracking, job build.
	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_char  (in_char),
		.in_last  (in_last),
		.job_push (job_push),
		.job      (new_job)
	);

	// Job queue: one entry per result-producing character.
	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_job  (new_job),
		.rd_en   (head_done),
		.rd_job  (head_job),
		.q_full  (full),
		.q_empty (q_empty)
	);

	// Back: serializes each job's bytes into the output register; the
	// last flag lands on the job's final byte only.
	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_job),
		.head_ok   (!q_empty),
		.head_done (head_done),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.out_valid (out_valid),
		.out_last  (out_last)
	);

endmodule

>>> sv/b64d_checker.sv
// b64d_checker: port-level assertions for the lenient Base64 decoder core,
// plus the bind that attaches it. Depends on base64_lenient_decoder_core.
module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       out_valid,
	input logic       out_last
);

	// A waiting result holds until it is popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_valid)
			&& $stable(out_last)))
		else $error("waiting result changed before pop");

	// The empty end marker always closes its message.
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_valid) |-> out_last)
		else $error("empty marker without last flag");

	// The empty end marker carries a zero byte.
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_valid) |-> (out_byte == 8'd0))
		else $error("empty marker with nonzero byte");

	// In reset nothing is waiting and the input side is open.
	a_reset: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("outputs not cleared by reset");

endmodule

bind base64_lenient_decoder_core b64d_checker u_b64d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.out_byte  (out_byte),
	.out_valid (out_valid),
	.out_last  (out_last)
);
